[hdl/iso_datetime_text_parser_top_macros.svh]
// Assertion macros for the date-time parser checker.
// Needs nothing else; included by the checker file only.
`ifndef ISO_DATETIME_TEXT_PARSER_TOP_MACROS_SVH
`define ISO_DATETIME_TEXT_PARSER_TOP_MACROS_SVH

// Same-cycle implication, held off while reset is low
`define IDTP_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, held off while reset is low
`define IDTP_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[hdl/idtp_pkg.sv]
// Shared types and constants of the ISO date-time text parser.
// No dependencies; imported by every module of the block.
`timescale 1ns / 1ps

package idtp_pkg;

    // One request: a single character of the string
    typedef struct packed {
        logic [7:0] char_code;
        logic       is_last;
    } item_t;

    // One result: all decoded fields of a string
    typedef struct packed {
        logic        ok;
        logic [13:0] year;
        logic [6:0]  month;
        logic [6:0]  day;
        logic [6:0]  hour;
        logic [6:0]  minute;
        logic [6:0]  second;
        logic [1:0]  zone_kind;
        logic [12:0] zone_minutes;
    } result_t;

    // Parse position, one-hot; successor of a plain step is a left shift
    typedef enum logic [25:0] {
        P_Y0       = 26'b1 << 0,
        P_Y1       = 26'b1 << 1,
        P_Y2       = 26'b1 << 2,
        P_Y3       = 26'b1 << 3,
        P_DASH1    = 26'b1 << 4,
        P_MO0      = 26'b1 << 5,
        P_MO1      = 26'b1 << 6,
        P_DASH2    = 26'b1 << 7,
        P_D0       = 26'b1 << 8,
        P_D1       = 26'b1 << 9,
        P_DATE_END = 26'b1 << 10,
        P_H0       = 26'b1 << 11,
        P_H1       = 26'b1 << 12,
        P_COLON1   = 26'b1 << 13,
        P_MI0      = 26'b1 << 14,
        P_MI1      = 26'b1 << 15,
        P_COLON2   = 26'b1 << 16,
        P_S0       = 26'b1 << 17,
        P_S1       = 26'b1 << 18,
        P_TIME_END = 26'b1 << 19,
        P_ZH0      = 26'b1 << 20,
        P_ZH1      = 26'b1 << 21,
        P_ZCOLON   = 26'b1 << 22,
        P_ZM0      = 26'b1 << 23,
        P_ZM1      = 26'b1 << 24,
        P_DONE     = 26'b1 << 25
    } pos_t;

    // Zone kind codes
    localparam logic [1:0] ZONE_NONE  = 2'd0;
    localparam logic [1:0] ZONE_Z     = 2'd1;
    localparam logic [1:0] ZONE_PLUS  = 2'd2;
    localparam logic [1:0] ZONE_MINUS = 2'd3;

    // Character codes
    localparam logic [7:0] CH_PLUS  = 8'h2B;
    localparam logic [7:0] CH_MINUS = 8'h2D;
    localparam logic [7:0] CH_ZULU  = 8'h5A;
    localparam logic [7:0] CH_TSEP  = 8'h54;
    localparam logic [7:0] CH_COLON = 8'h3A;
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_NINE  = 8'h39;

    localparam logic [12:0] MIN_PER_HOUR = 13'd60;

    // Running parse state of one string
    typedef struct packed {
        pos_t        pos;
        logic [13:0] accum;
        logic [13:0] year;
        logic [6:0]  month;
        logic [6:0]  day;
        logic [6:0]  hour;
        logic [6:0]  minute;
        logic [6:0]  second;
        logic [1:0]  zone_kind;
        logic [6:0]  zone_hour;
        logic [6:0]  zone_minute;
        logic        err;
    } parse_state_t;

    localparam parse_state_t STATE_RESET = '{
        pos:         P_Y0,
        accum:       14'd0,
        year:        14'd0,
        month:       7'd0,
        day:         7'd0,
        hour:        7'd0,
        minute:      7'd0,
        second:      7'd0,
        zone_kind:   ZONE_NONE,
        zone_hour:   7'd0,
        zone_minute: 7'd0,
        err:         1'b0
    };

    // Control from the parse stage to the result register
    typedef struct packed {
        logic load;
        logic ok;
    } res_ctl_t;

endpackage

[hdl/idtp_step.sv]
// Next-state logic of the parser: one character against the grammar.
// Depends on idtp_pkg.
`timescale 1ns / 1ps

module idtp_step
    import idtp_pkg::*;
(
    input  parse_state_t cur,
    input  logic [7:0]   char_code,
    output parse_state_t nxt,
    output logic         ok
);

    logic        is_digit;
    logic [13:0] acc_x10;
    logic [13:0] acc_new;
    pos_t        succ;

    // Decimal accumulate, kept to 14 bits
    assign is_digit = (char_code >= CH_ZERO) && (char_code <= CH_NINE);
    assign acc_x10  = {cur.accum[10:0], 3'b000} + {cur.accum[12:0], 1'b0};
    assign acc_new  = acc_x10 + {10'd0, char_code[3:0]};
    assign succ     = pos_t'(cur.pos << 1);

    // Advance the position, store finished groups, flag mismatches
    always_comb
    begin
        nxt = cur;
        if (!cur.err)
        begin
            if ((cur.pos == P_Y2) && (char_code == CH_COLON))
            begin
                // time-only form: two digits taken so far are the hours
                nxt.hour  = cur.accum[6:0];
                nxt.accum = 14'd0;
                nxt.pos   = P_MI0;
            end
            else
            begin
                case (cur.pos)
                    P_Y0, P_Y1, P_Y2, P_MO0, P_D0, P_H0, P_MI0, P_S0, P_ZH0, P_ZM0:
                    begin
                        if (!is_digit)
                            nxt.err = 1'b1;
                        else
                        begin
                            nxt.accum = acc_new;
                            nxt.pos   = succ;
                        end
                    end
                    P_Y3, P_MO1, P_D1, P_H1, P_MI1, P_S1, P_ZH1, P_ZM1:
                    begin
                        if (!is_digit)
                            nxt.err = 1'b1;
                        else
                        begin
                            nxt.accum = 14'd0;
                            nxt.pos   = succ;
                            case (cur.pos)
                                P_Y3:    nxt.year        = acc_new;
                                P_MO1:   nxt.month       = acc_new[6:0];
                                P_D1:    nxt.day         = acc_new[6:0];
                                P_H1:    nxt.hour        = acc_new[6:0];
                                P_MI1:   nxt.minute      = acc_new[6:0];
                                P_S1:    nxt.second      = acc_new[6:0];
                                P_ZH1:   nxt.zone_hour   = acc_new[6:0];
                                default: nxt.zone_minute = acc_new[6:0];
                            endcase
                        end
                    end
                    P_DASH1, P_DASH2:
                    begin
                        if (char_code == CH_MINUS)
                            nxt.pos = succ;
                        else
                            nxt.err = 1'b1;
                    end
                    P_COLON1, P_COLON2, P_ZCOLON:
                    begin
                        if (char_code == CH_COLON)
                            nxt.pos = succ;
                        else
                            nxt.err = 1'b1;
                    end
                    P_DATE_END, P_TIME_END:
                    begin
                        if ((cur.pos == P_DATE_END) && (char_code == CH_TSEP))
                            nxt.pos = P_H0;
                        else if (char_code == CH_ZULU)
                        begin
                            nxt.zone_kind = ZONE_Z;
                            nxt.pos       = P_DONE;
                        end
                        else if (char_code == CH_PLUS)
                        begin
                            nxt.zone_kind = ZONE_PLUS;
                            nxt.pos       = P_ZH0;
                        end
                        else if (char_code == CH_MINUS)
                        begin
                            nxt.zone_kind = ZONE_MINUS;
                            nxt.pos       = P_ZH0;
                        end
                        else
                            nxt.err = 1'b1;
                    end
                    default:
                    begin
                        // anything after a complete zone
                        nxt.err = 1'b1;
                    end
                endcase
            end
        end
    end

    // A string may end after a date, a time or a zone
    assign ok = !nxt.err &&
                ((nxt.pos == P_DATE_END) || (nxt.pos == P_TIME_END) || (nxt.pos == P_DONE));

endmodule

[hdl/idtp_result.sv]
// Result register of the parser: formats the finished state into one result.
// Depends on idtp_pkg.
`timescale 1ns / 1ps

module idtp_result
    import idtp_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  res_ctl_t     ctl,
    input  parse_state_t fin,
    input  logic         result_stall,
    output logic         result_valid,
    output result_t      result
);

    logic        result_valid_reg;
    logic        result_valid_next;
    result_t     result_reg;
    result_t     result_next;
    logic [12:0] zone_total;

    // Offset in minutes, only for a numeric zone
    assign zone_total = (13'(fin.zone_hour) * MIN_PER_HOUR) + {6'd0, fin.zone_minute};

    // Build the result; a failed string reports all fields zero
    always_comb
    begin
        result_next = '0;
        if (ctl.ok)
        begin
            result_next.ok        = 1'b1;
            result_next.year      = fin.year;
            result_next.month     = fin.month;
            result_next.day       = fin.day;
            result_next.hour      = fin.hour;
            result_next.minute    = fin.minute;
            result_next.second    = fin.second;
            result_next.zone_kind = fin.zone_kind;
            if ((fin.zone_kind == ZONE_PLUS) || (fin.zone_kind == ZONE_MINUS))
                result_next.zone_minutes = zone_total;
        end
    end

    // Hold the result until taken; a new one may replace it on the same edge
    assign result_valid_next = ctl.load || (result_valid_reg && result_stall);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            result_valid_reg <= 1'b0;
        else
            result_valid_reg <= result_valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (ctl.load)
            result_reg <= result_next;
    end

    assign result_valid = result_valid_reg;
    assign result       = result_reg;

endmodule

[hdl/iso_datetime_text_parser_top.sv]
// Path: the last character passes the input register, then the result register
// loads its result and raises result_valid.
// Throughput: one character per cycle; the input stalls only when a last
// character meets a result that is still waiting to be taken.
// Reset: asynchronous, active low; clears the parse state and both valid flags.
// Depends on idtp_pkg, idtp_step and idtp_result.
`timescale 1ns / 1ps

module iso_datetime_text_parser_top
    import idtp_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    item_valid,
    output logic    item_stall,
    input  item_t   item,
    output logic    result_valid,
    input  logic    result_stall,
    output result_t result
);

    logic         in_valid_reg;
    logic         in_valid_next;
    item_t        in_data_reg;
    parse_state_t state_reg;
    parse_state_t state_next;
    parse_state_t step_state;
    logic         step_ok;
    logic         step_go;
    logic         fire;
    res_ctl_t     ctl;

    // Only a last character waits, and only behind an untaken result
    assign step_go    = !(in_data_reg.is_last && result_valid && result_stall);
    assign item_stall = in_valid_reg && !step_go;
    assign fire       = in_valid_reg && step_go;

    // Input register
    assign in_valid_next = item_stall ? in_valid_reg : item_valid;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            in_valid_reg <= 1'b0;
        else
            in_valid_reg <= in_valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (!item_stall)
            in_data_reg <= item;
    end

    idtp_step u_step (
        .cur       (state_reg),
        .char_code (in_data_reg.char_code),
        .nxt       (step_state),
        .ok        (step_ok)
    );

    // Advance the parse state; return to reset after the last character
    always_comb
    begin
        state_next = state_reg;
        if (fire)
        begin
            if (in_data_reg.is_last)
                state_next = STATE_RESET;
            else
                state_next = step_state;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= STATE_RESET;
        else
            state_reg <= state_next;
    end

    assign ctl.load = fire && in_data_reg.is_last;
    assign ctl.ok   = step_ok;

    idtp_result u_result (
        .clk          (clk),
        .rst_n        (rst_n),
        .ctl          (ctl),
        .fin          (step_state),
        .result_stall (result_stall),
        .result_valid (result_valid),
        .result       (result)
    );

endmodule

[hdl/idtp_checker.sv]
// Port-level checks of the date-time parser, bound to the top level.
// Depends on idtp_pkg and iso_datetime_text_parser_top_macros.svh.
`timescale 1ns / 1ps

`include "iso_datetime_text_parser_top_macros.svh"

module idtp_checker
    import idtp_pkg::*;
(
    input logic    clk,
    input logic    rst_n,
    input logic    item_valid,
    input logic    item_stall,
    input item_t   item,
    input logic    result_valid,
    input logic    result_stall,
    input result_t result
);

    // A stalled result keeps its value
    `IDTP_ASSERT_NEXT(a_result_held, clk, rst_n, result_valid && result_stall, result_valid && $stable(result), "stalled result changed")

    // A failed string reports no fields
    `IDTP_ASSERT_NOW(a_fail_zero, clk, rst_n, result_valid && !result.ok, (result.year == 14'd0) && (result.month == 7'd0) && (result.day == 7'd0) && (result.hour == 7'd0) && (result.minute == 7'd0) && (result.second == 7'd0) && (result.zone_kind == ZONE_NONE) && (result.zone_minutes == 13'd0), "failed result carries data")

    // An offset appears only with a numeric zone
    `IDTP_ASSERT_NOW(a_zone_offset, clk, rst_n, result_valid && ((result.zone_kind == ZONE_NONE) || (result.zone_kind == ZONE_Z)), result.zone_minutes == 13'd0, "offset without numeric zone")

    // A fresh result follows an accepted last character
    `IDTP_ASSERT_NOW(a_result_source, clk, rst_n, $rose(result_valid), $past(item_valid && !item_stall && item.is_last, 2), "result without last character")

endmodule

bind iso_datetime_text_parser_top idtp_checker u_idtp_checker (.*);
